// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, sizes and codes for the scan packet classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int SLOT_COUNT   = 5;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int SCAN_MODULUS = 8;
    localparam int SCAN_W       = 3;
    localparam int KIND_W       = 2;
    localparam int TIME_W       = 62;
    localparam int TOL_W        = 32;
    localparam int SUM_W        = TIME_W + 2;
    localparam int STAGE_W      = 2;
    localparam int VERDICT_W    = 2;

    // Stream widths: fields packed from bit 0 up, tdata widths padded to whole bytes.
    localparam int S_TDATA_RAW  = SCAN_W + TIME_W + TIME_W + 1 + TIME_W + SCAN_W;
    localparam int S_TDATA_W    = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int S_TUSER_W    = 1 + KIND_W;
    localparam int M_TDATA_W    = ((VERDICT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TIME_TOL = '0;

    // Duplicate-time stage of a sector slot.
    localparam logic [STAGE_W-1:0] STAGE_NONE   = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_SINGLE = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SHARED = 2'd2;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_IN_SCAN   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NEXT_SCAN = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SCAN_BAD  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TIME_BAD  = 2'd3;

    typedef struct packed {
        logic              is_calibration;
        logic [KIND_W-1:0] cal_kind;
        logic [SCAN_W-1:0] scan_number;
        logic [TIME_W-1:0] packet_time;
        logic [TIME_W-1:0] next_scan_start;
        logic              lookahead_valid;
        logic [TIME_W-1:0] lookahead_time;
        logic [SCAN_W-1:0] lookahead_scan;
    } spc_item_t;

endpackage

// ===== rtl/spc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spc_cfg_regs
// APB register file holding the time tolerance.
// ----------------------------------------------------------------------------
module spc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [spc_pkg::TOL_W-1:0]       time_tol
);

    logic [spc_pkg::TOL_W-1:0]     tol_reg;
    logic [spc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_tol;

    assign reg_idx = paddr[spc_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_tol  = psel && penable && pwrite && (reg_idx == spc_pkg::REG_TIME_TOL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (wr_tol) begin
            tol_reg <= pwdata[spc_pkg::TOL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == spc_pkg::REG_TIME_TOL) begin
            prdata[spc_pkg::TOL_W-1:0] = tol_reg;
        end
    end

    assign time_tol = tol_reg;

endmodule

// ===== rtl/spc_in_reg.sv =====
// ----------------------------------------------------------------------------
// spc_in_reg
// Input register: captures one header beat and unpacks its fields.
// ----------------------------------------------------------------------------
module spc_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [spc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           item_valid,
    input  logic                           item_ready,
    output spc_pkg::spc_item_t             item
);

    logic               valid_reg;
    spc_pkg::spc_item_t item_reg;
    spc_pkg::spc_item_t item_next;

    assign s_tready = !valid_reg || item_ready;

    always_comb begin
        item_next.is_calibration  = s_tuser[0];
        item_next.cal_kind        = s_tuser[spc_pkg::KIND_W:1];
        item_next.scan_number     = s_tdata[2:0];
        item_next.packet_time     = s_tdata[64:3];
        item_next.next_scan_start = s_tdata[126:65];
        item_next.lookahead_valid = s_tdata[127];
        item_next.lookahead_time  = s_tdata[189:128];
        item_next.lookahead_scan  = s_tdata[192:190];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (item_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/spc_core.sv =====
// ----------------------------------------------------------------------------
// spc_core
// Scan and sector-slot state, verdict logic and the result register.
// ----------------------------------------------------------------------------
module spc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [spc_pkg::TOL_W-1:0]       time_tol,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  spc_pkg::spc_item_t              item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spc_pkg::VERDICT_W-1:0]   verdict
);

    logic                                adv;
    logic                                have_scan_reg;
    logic [spc_pkg::SCAN_W-1:0]          last_scan_reg;
    logic [spc_pkg::SCAN_W-1:0]          last_scan_next;
    logic [spc_pkg::TIME_W-1:0]          slot_time_reg  [spc_pkg::SLOT_COUNT];
    logic [spc_pkg::TIME_W-1:0]          slot_time_next [spc_pkg::SLOT_COUNT];
    logic [spc_pkg::STAGE_W-1:0]         slot_stage_reg  [spc_pkg::SLOT_COUNT];
    logic [spc_pkg::STAGE_W-1:0]         slot_stage_next [spc_pkg::SLOT_COUNT];
    logic                                out_valid_reg;
    logic [spc_pkg::VERDICT_W-1:0]       verdict_reg;
    logic [spc_pkg::VERDICT_W-1:0]       verdict_next;

    logic [spc_pkg::SLOT_W-1:0]          slot;
    logic [spc_pkg::SCAN_W-1:0]          cur_scan;
    logic [spc_pkg::SCAN_W-1:0]          succ_scan;
    logic [spc_pkg::STAGE_W-1:0]         cur_stage;
    logic [spc_pkg::SUM_W-1:0]           time_sum;
    logic                                by_time;
    logic                                take_next;
    logic                                start_scan;
    logic                                any_stage_set;
    logic                                any_stage_bad;

    assign adv        = item_valid && (!out_valid_reg || m_tready);
    assign item_ready = adv;

    always_comb begin
        slot = spc_pkg::SLOT_W'(spc_pkg::SLOT_COUNT - 1);
        if (item.is_calibration && (32'(item.cal_kind) < 32'(spc_pkg::SLOT_COUNT - 1))) begin
            slot = spc_pkg::SLOT_W'(item.cal_kind);
        end

        // Before the first packet the scan count is taken from the packet itself.
        cur_scan  = have_scan_reg ? last_scan_reg : item.scan_number;
        cur_stage = have_scan_reg ? slot_stage_reg[slot] : spc_pkg::STAGE_NONE;
        succ_scan = (cur_scan == spc_pkg::SCAN_W'(spc_pkg::SCAN_MODULUS - 1)) ? '0
                  : cur_scan + spc_pkg::SCAN_W'(1);

        time_sum = {2'b00, item.packet_time} + spc_pkg::SUM_W'(time_tol);
        by_time  = time_sum >= {2'b00, item.next_scan_start};

        take_next = !item.lookahead_valid ||
                    ((succ_scan == item.scan_number) &&
                     ((item.lookahead_time >= item.next_scan_start) ||
                      (item.lookahead_scan == item.scan_number)));

        last_scan_next = cur_scan;
        slot_time_next = slot_time_reg;
        for (int i = 0; i < spc_pkg::SLOT_COUNT; i++) begin
            slot_stage_next[i] = have_scan_reg ? slot_stage_reg[i] : spc_pkg::STAGE_NONE;
        end
        verdict_next = spc_pkg::VERDICT_IN_SCAN;
        start_scan   = 1'b0;

        if (by_time) begin
            start_scan = 1'b1;
        end else if (item.scan_number != cur_scan) begin
            if (take_next) begin
                start_scan = 1'b1;
            end else begin
                verdict_next = spc_pkg::VERDICT_SCAN_BAD;
            end
        end else begin
            case (cur_stage)
                spc_pkg::STAGE_NONE: begin
                    slot_time_next[slot]  = item.packet_time;
                    slot_stage_next[slot] = spc_pkg::STAGE_SINGLE;
                end
                spc_pkg::STAGE_SINGLE: begin
                    if (slot_time_reg[slot] == item.packet_time) begin
                        slot_stage_next[slot] = spc_pkg::STAGE_SHARED;
                    end else begin
                        slot_time_next[slot] = item.packet_time;
                    end
                end
                spc_pkg::STAGE_SHARED: begin
                    if (slot_time_reg[slot] != item.packet_time) begin
                        verdict_next = spc_pkg::VERDICT_TIME_BAD;
                    end
                end
                default: begin
                end
            endcase
        end

        if (start_scan) begin
            verdict_next   = spc_pkg::VERDICT_NEXT_SCAN;
            last_scan_next = item.scan_number;
            for (int i = 0; i < spc_pkg::SLOT_COUNT; i++) begin
                slot_stage_next[i] = spc_pkg::STAGE_NONE;
            end
            slot_stage_next[slot] = spc_pkg::STAGE_SINGLE;
            slot_time_next[slot]  = item.packet_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_scan_reg <= 1'b0;
            last_scan_reg <= '0;
            for (int i = 0; i < spc_pkg::SLOT_COUNT; i++) begin
                slot_stage_reg[i] <= spc_pkg::STAGE_NONE;
            end
        end else if (adv) begin
            have_scan_reg  <= 1'b1;
            last_scan_reg  <= last_scan_next;
            slot_stage_reg <= slot_stage_next;
        end
    end

    // Slot times are only read while their stage is not empty.
    always_ff @(posedge aclk) begin
        if (adv) begin
            slot_time_reg <= slot_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign verdict  = verdict_reg;

    always_comb begin
        any_stage_set = 1'b0;
        any_stage_bad = 1'b0;
        for (int i = 0; i < spc_pkg::SLOT_COUNT; i++) begin
            any_stage_set = any_stage_set || (slot_stage_reg[i] != spc_pkg::STAGE_NONE);
            any_stage_bad = any_stage_bad || (slot_stage_reg[i] > spc_pkg::STAGE_SHARED);
        end
    end

    a_new_scan_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && verdict_next == spc_pkg::VERDICT_NEXT_SCAN)
        |=> (have_scan_reg && last_scan_reg == $past(item.scan_number)))
        else $error("new scan did not take the packet scan count");

    a_bad_count_keeps_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && verdict_next == spc_pkg::VERDICT_SCAN_BAD) |=> $stable(last_scan_reg))
        else $error("rejected scan count changed the current scan");

    a_no_slots_before_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_scan_reg |-> !any_stage_set)
        else $error("slot stage set before any scan was seen");

    a_stage_never_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_stage_bad)
        else $error("slot reached the unused stage code");

    a_result_follows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("accepted header produced no result");

endmodule

// ===== rtl/scan_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// scan_packet_classifier
// Classifies instrument packet headers against the current scan: in scan,
// next scan, bad scan count or bad packet time.
//
//   Channel   Direction  Payload
//   s_*       in         header beat: tdata fields, tuser calibration info
//   m_*       out        one verdict per header beat
//   APB       in/out     time tolerance register at byte address 0
//
// One header beat is accepted every cycle unless a stalled m_tready holds the
// core; its verdict passes through the input register, then the result
// register, to m_tdata.
// The whole classification and slot update is one pass of logic between the
// input register and the result register, so consecutive beats see each
// other's state updates with no gap.
// Reset clears scan state, slot stages and the tolerance register.
// A stalled m_tready holds the result register and stops s_tready only once
// the input register is also full.
// ----------------------------------------------------------------------------
module scan_packet_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, from bit 0: scan_number, packet_time, next_scan_start,
    // lookahead_valid, lookahead_time, lookahead_scan, zero padding
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser, from bit 0: is_calibration, cal_kind
    input  logic [spc_pkg::S_TUSER_W-1:0]   s_tuser,
    // m_tdata, from bit 0: verdict, zero padding
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [spc_pkg::TOL_W-1:0]      time_tol;
    logic                           item_valid;
    logic                           item_ready;
    spc_pkg::spc_item_t             item;
    logic [spc_pkg::VERDICT_W-1:0]  verdict;

    spc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .time_tol (time_tol)
    );

    spc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    spc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .time_tol   (time_tol),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .verdict    (verdict)
    );

    assign m_tdata = {{(spc_pkg::M_TDATA_W - spc_pkg::VERDICT_W){1'b0}}, verdict};

endmodule
